FILE: sv/cfpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfpr_pkg;

	localparam int MAX_PACKET_BYTES = 512;
	localparam int SEQUENCE_BITS    = 7;

	localparam int ID_W       = 29;
	localparam int LEN_W      = 4;
	localparam int FRAME_W    = 64;
	localparam int PAYLOAD_W  = 56;
	localparam int COUNT_W    = 3;
	localparam int PLEN_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 29;
	localparam int MAX_LEN    = 8;
	localparam int LAST_BIT   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_FRAME_ID        = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_EXTENDED_FORMAT = 1'd1;

	typedef enum logic [2:0] {
		ST_NOT_OURS = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NO_START = 3'd2,
		ST_ACCEPTED = 3'd3,
		ST_COMPLETE = 3'd4,
		ST_OVERSIZE = 3'd5
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]    frame_id;
		logic               frame_extended;
		logic               frame_remote;
		logic [LEN_W-1:0]   frame_length;
		logic [FRAME_W-1:0] frame_bytes;
	} frame_t;

	typedef struct packed {
		status_t              status;
		logic                 abort_previous;
		logic                 packet_start;
		logic                 packet_end;
		logic [COUNT_W-1:0]   deliver_count;
		logic [PAYLOAD_W-1:0] deliver_bytes;
		logic [PLEN_W-1:0]    packet_length;
	} result_t;

	// Byte mask that keeps the lowest count bytes of the payload
	function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
		logic [PAYLOAD_W-1:0] m;
		m = '0;
		for (int k = 0; k < PAYLOAD_W / 8; k++) begin
			if (k < int'(count)) begin
				m[k*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: sv/cfpr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cfpr_frame_if;
	logic              valid;
	logic              ready;
	cfpr_pkg::frame_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cfpr_result_if;
	logic              valid;
	logic              ready;
	cfpr_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/can_frame_packet_reassembler_unit.sv
// A frame is held in the input register, then its result in the result register; result valid
// rises as the result register loads, which a stalled result output can hold off.
// Throughput: one frame per cycle unless result_out stalls; the reassembly state updates as a
// frame leaves the input register, so back-to-back frames see each other's effect.
// Reset (arst_n low, asynchronous): idle, expected sequence and byte count zero,
// own_frame_id 0, use_extended_format 0, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module can_frame_packet_reassembler_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cfpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cfpr_pkg::CFG_DATA_W-1:0]     cfg_data,
	cfpr_frame_if.sink                               frame_in,
	cfpr_result_if.source                            result_out
);

	logic [cfpr_pkg::ID_W-1:0]          own_frame_id_q;
	logic                               use_extended_format_q;

	logic                               receiving_q;
	logic [cfpr_pkg::SEQUENCE_BITS-1:0] expected_sequence_q;
	logic [cfpr_pkg::PLEN_W-1:0]        byte_count_q;

	logic                               valid_s1;
	cfpr_pkg::frame_t                   frame_s1;
	logic                               valid_s2;
	cfpr_pkg::result_t                  result_s2;

	logic                               advance;

	// Frame decode
	logic [cfpr_pkg::LEN_W-1:0]         len_sat;
	logic                               match;
	logic [cfpr_pkg::SEQUENCE_BITS-1:0] seq;
	logic                               last;
	logic [cfpr_pkg::COUNT_W-1:0]       payload;
	logic                               seq_abort;
	logic                               recv_cont;
	logic                               start_new;
	logic [cfpr_pkg::PLEN_W:0]          sum;
	logic                               oversize;

	cfpr_pkg::result_t                  result_d;
	logic                               receiving_d;
	logic [cfpr_pkg::SEQUENCE_BITS-1:0] expected_sequence_d;
	logic [cfpr_pkg::PLEN_W-1:0]        byte_count_d;

	assign advance        = valid_s1 && (!valid_s2 || result_out.ready);
	assign frame_in.ready = !valid_s1 || advance;
	assign result_out.valid = valid_s2;
	assign result_out.data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_frame_id_q        <= '0;
			use_extended_format_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cfpr_pkg::REG_OWN_FRAME_ID:        own_frame_id_q <= cfg_data;
				cfpr_pkg::REG_USE_EXTENDED_FORMAT: use_extended_format_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len_sat = (frame_s1.frame_length > cfpr_pkg::LEN_W'(cfpr_pkg::MAX_LEN))
			? cfpr_pkg::LEN_W'(cfpr_pkg::MAX_LEN) : frame_s1.frame_length;
		match   = (frame_s1.frame_id == own_frame_id_q)
			&& (frame_s1.frame_extended == use_extended_format_q)
			&& !frame_s1.frame_remote;
		seq     = frame_s1.frame_bytes[cfpr_pkg::SEQUENCE_BITS-1:0];
		last    = frame_s1.frame_bytes[cfpr_pkg::LAST_BIT];
		payload = cfpr_pkg::COUNT_W'(len_sat - cfpr_pkg::LEN_W'(1));

		// a sequence gap drops the packet in progress, then the frame is judged as idle
		seq_abort = receiving_q && (seq != expected_sequence_q);
		recv_cont = receiving_q && !seq_abort;
		start_new = !recv_cont && (seq == '0);
		sum       = (recv_cont ? {1'b0, byte_count_q} : '0)
			+ (cfpr_pkg::PLEN_W + 1)'(payload);
		oversize  = sum > (cfpr_pkg::PLEN_W + 1)'(cfpr_pkg::MAX_PACKET_BYTES);

		result_d            = '0;
		receiving_d         = receiving_q;
		expected_sequence_d = expected_sequence_q;
		byte_count_d        = byte_count_q;

		if (!match) begin
			result_d.status = cfpr_pkg::ST_NOT_OURS;
		end else if (len_sat == '0) begin
			result_d.status = cfpr_pkg::ST_EMPTY;
		end else begin
			result_d.abort_previous = seq_abort;
			receiving_d         = 1'b0;
			expected_sequence_d = '0;
			byte_count_d        = '0;
			if (!recv_cont && !start_new) begin
				result_d.status = cfpr_pkg::ST_NO_START;
			end else if (oversize) begin
				result_d.status         = cfpr_pkg::ST_OVERSIZE;
				result_d.abort_previous = 1'b1;
			end else begin
				result_d.packet_start  = start_new;
				result_d.deliver_count = payload;
				result_d.deliver_bytes = frame_s1.frame_bytes[cfpr_pkg::FRAME_W-1:8]
					& cfpr_pkg::byte_mask(payload);
				result_d.packet_length = sum[cfpr_pkg::PLEN_W-1:0];
				if (last) begin
					result_d.status     = cfpr_pkg::ST_COMPLETE;
					result_d.packet_end = 1'b1;
				end else begin
					result_d.status     = cfpr_pkg::ST_ACCEPTED;
					receiving_d         = 1'b1;
					byte_count_d        = sum[cfpr_pkg::PLEN_W-1:0];
					expected_sequence_d = seq + cfpr_pkg::SEQUENCE_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1            <= 1'b0;
			valid_s2            <= 1'b0;
			receiving_q         <= 1'b0;
			expected_sequence_q <= '0;
			byte_count_q        <= '0;
		end else begin
			if (frame_in.ready) begin
				valid_s1 <= frame_in.valid;
			end
			if (advance) begin
				valid_s2            <= 1'b1;
				receiving_q         <= receiving_d;
				expected_sequence_q <= expected_sequence_d;
				byte_count_q        <= byte_count_d;
			end else if (result_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			frame_s1 <= frame_in.data;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/cfpr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cfpr_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire cfpr_pkg::result_t out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// end mark goes with complete status and nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.packet_end == (out_data.status == cfpr_pkg::ST_COMPLETE)))
		else $error("packet_end disagrees with status");

	// dropped frames deliver nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == cfpr_pkg::ST_NOT_OURS
			|| out_data.status == cfpr_pkg::ST_EMPTY
			|| out_data.status == cfpr_pkg::ST_NO_START
			|| out_data.status == cfpr_pkg::ST_OVERSIZE)
		|-> out_data.deliver_count == '0 && out_data.deliver_bytes == '0
			&& out_data.packet_length == '0 && !out_data.packet_start)
		else $error("dropped frame delivered data");

	// oversize always aborts the packet
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == cfpr_pkg::ST_OVERSIZE |-> out_data.abort_previous)
		else $error("oversize without abort");

endmodule

bind can_frame_packet_reassembler_unit cfpr_checker u_cfpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_data  (result_out.data)
);

`default_nettype wire
